>>> rtl/swsu_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and control types of the window statistics unit.
package swsu_pkg;

    // Window limit and sample width
    localparam int MAX_WINDOW  = 4096;
    localparam int SAMPLE_BITS = 16;

    // Derived widths
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int SQSUM_W = SQ_W + $clog2(MAX_WINDOW);
    localparam int ROOT_W  = SAMPLE_BITS;
    localparam int STEP_W  = $clog2(SQSUM_W);

    // Window queue between the accumulator and the arithmetic back end
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Reset values of the running minimum and maximum
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // One input transaction
    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_sample_item;

    // One result transaction
    typedef struct packed {
        logic signed [15:0] mean_value;
        logic        [15:0] rms_value;
        logic signed [15:0] minimum;
        logic signed [15:0] maximum;
        logic        [15:0] peak_to_peak;
        logic        [12:0] sample_count;
        logic               overflow;
    } t_stat_item;

    // Totals of one closed window
    typedef struct packed {
        logic signed [SUM_W-1:0]       sum;
        logic        [SQSUM_W-1:0]     sq_sum;
        logic signed [SAMPLE_BITS-1:0] min_val;
        logic signed [SAMPLE_BITS-1:0] max_val;
        logic        [CNT_W-1:0]       count;
        logic                          ovf;
    } t_window_rec;

    // Queue status seen by both neighbors
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_HOLD
    } t_back_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic sqrt_step;
        logic out_load;
    } t_back_ctl;

endpackage

>>> rtl/swsu_front.sv
`timescale 1ns / 1ps
// Front end: takes samples, squares them and keeps the running window totals.
module swsu_front
    import swsu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         push,
    output logic         full,
    input  t_sample_item i_sample_item,
    input  t_q_status    i_q_status,
    output logic         o_rec_push,
    output t_window_rec  o_rec
);

    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic        [SQ_W-1:0]        r_s1_sq;
    logic                          r_s1_last;

    logic signed [SUM_W-1:0]       r_sum,  n_sum;
    logic        [SQSUM_W-1:0]     r_sq,   n_sq;
    logic signed [SAMPLE_BITS-1:0] r_min,  n_min;
    logic signed [SAMPLE_BITS-1:0] r_max,  n_max;
    logic        [CNT_W-1:0]       r_cnt,  n_cnt;
    logic                          r_ovf,  n_ovf;

    logic                   w_stall;
    logic                   w_adv;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [2*SAMPLE_BITS-1:0] w_prod;

    // A closing sample waits in the stage while the queue has no room.
    assign w_stall = r_s1_valid && r_s1_last && i_q_status.full;
    assign w_adv   = r_s1_valid && !w_stall;
    assign full    = w_stall;

    // Magnitude and square of the incoming sample.
    assign w_mag  = i_sample_item.sample[SAMPLE_BITS-1] ?
                    SAMPLE_BITS'(-i_sample_item.sample) :
                    SAMPLE_BITS'(i_sample_item.sample);
    assign w_prod = w_mag * w_mag;

    // Input stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!w_stall) begin
            r_s1_valid <= push;
        end
        if (!w_stall && push) begin
            r_s1_sample <= i_sample_item.sample;
            r_s1_sq     <= w_prod[SQ_W-1:0];
            r_s1_last   <= i_sample_item.last;
        end
    end

    // Running totals after the staged sample; a full window only marks overflow.
    always_comb begin
        n_sum = r_sum;
        n_sq  = r_sq;
        n_min = r_min;
        n_max = r_max;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (r_cnt >= CNT_W'(MAX_WINDOW)) begin
            n_ovf = 1'b1;
        end else begin
            n_sum = r_sum + {{(SUM_W-SAMPLE_BITS){r_s1_sample[SAMPLE_BITS-1]}}, r_s1_sample};
            n_sq  = r_sq + SQSUM_W'(r_s1_sq);
            if (r_s1_sample < r_min) begin
                n_min = r_s1_sample;
            end
            if (r_s1_sample > r_max) begin
                n_max = r_s1_sample;
            end
            n_cnt = r_cnt + 1'b1;
        end
    end

    // The closing sample hands the finished window to the queue.
    assign o_rec_push     = w_adv && r_s1_last;
    assign o_rec.sum      = n_sum;
    assign o_rec.sq_sum   = n_sq;
    assign o_rec.min_val  = n_min;
    assign o_rec.max_val  = n_max;
    assign o_rec.count    = n_cnt;
    assign o_rec.ovf      = n_ovf;

    // Accumulator registers, cleared when a window closes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_adv && r_s1_last)) begin
            r_sum <= '0;
            r_sq  <= '0;
            r_min <= SMP_MAX;
            r_max <= SMP_MIN;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (w_adv) begin
            r_sum <= n_sum;
            r_sq  <= n_sq;
            r_min <= n_min;
            r_max <= n_max;
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    // Overflow is only ever flagged on a window that reached the limit.
    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_cnt == CNT_W'(MAX_WINDOW)))
        else $error("overflow set below the window limit");

endmodule

>>> rtl/swsu_queue.sv
`timescale 1ns / 1ps
// Short queue of closed-window totals between the front and back ends.
module swsu_queue
    import swsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_window_rec i_rec,
    input  logic        i_pop,
    output t_window_rec o_rec,
    output t_q_status   o_status
);

    t_window_rec       r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_rec          = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("window pushed into a full queue");

endmodule

>>> rtl/swsu_back.sv
`timescale 1ns / 1ps
// Back end: serial division, serial square root and the result register.
module swsu_back
    import swsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_status   i_q_status,
    input  t_window_rec i_rec,
    output logic        o_q_pop,
    output logic        empty,
    input  logic        pop,
    output t_stat_item  o_stat_item
);

    t_back_state r_state, n_state;
    t_back_ctl   ctl;

    logic [STEP_W-1:0]             r_step;
    logic                          r_neg;
    logic [SQSUM_W-1:0]            r_quo_a;
    logic [CNT_W-1:0]              r_rem_a;
    logic [SQSUM_W-1:0]            r_quo_b;
    logic [CNT_W-1:0]              r_rem_b;
    logic [ROOT_W-1:0]             r_root;
    logic [ROOT_W-1:0]             r_srem;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_ovf;
    logic                          r_out_valid;
    t_stat_item                    r_out;

    logic             w_out_free;
    logic [SUM_W-1:0] w_sum_mag;
    logic [CNT_W:0]   w_ta, w_tb, w_da, w_db;
    logic             w_ge_a, w_ge_b;
    logic [ROOT_W+1:0] w_cur, w_trial, w_sdiff;
    logic             w_ge_s;
    logic [SAMPLE_BITS-1:0] w_qa;
    t_stat_item       w_res;

    assign w_out_free = !r_out_valid || pop;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) n_state = BK_DIV;
            end
            BK_DIV: begin
                if (r_step == '0) n_state = BK_SQRT;
            end
            BK_SQRT: begin
                if (r_step == '0) n_state = BK_HOLD;
            end
            BK_HOLD: begin
                if (w_out_free) n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        ctl = '0;
        case (r_state)
            BK_IDLE: ctl.load      = !i_q_status.empty;
            BK_DIV:  ctl.div_step  = 1'b1;
            BK_SQRT: ctl.sqrt_step = 1'b1;
            BK_HOLD: ctl.out_load  = w_out_free;
            default: ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_q_pop = ctl.load;

    // Restoring division of both totals by the count, one quotient bit per cycle.
    assign w_sum_mag = i_rec.sum[SUM_W-1] ? SUM_W'(-i_rec.sum) : SUM_W'(i_rec.sum);
    assign w_ta   = {r_rem_a, r_quo_a[SQSUM_W-1]};
    assign w_tb   = {r_rem_b, r_quo_b[SQSUM_W-1]};
    assign w_ge_a = (w_ta >= {1'b0, r_cnt});
    assign w_ge_b = (w_tb >= {1'b0, r_cnt});
    assign w_da   = w_ta - {1'b0, r_cnt};
    assign w_db   = w_tb - {1'b0, r_cnt};

    // Digit-by-digit square root, two radicand bits per cycle.
    assign w_cur   = {r_srem, r_quo_b[2*ROOT_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge_s  = (w_cur >= w_trial);
    assign w_sdiff = w_cur - w_trial;

    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_neg   <= i_rec.sum[SUM_W-1];
            r_quo_a <= SQSUM_W'(w_sum_mag);
            r_rem_a <= '0;
            r_quo_b <= i_rec.sq_sum;
            r_rem_b <= '0;
            r_root  <= '0;
            r_srem  <= '0;
            r_min   <= i_rec.min_val;
            r_max   <= i_rec.max_val;
            r_cnt   <= i_rec.count;
            r_ovf   <= i_rec.ovf;
            r_step  <= STEP_W'(SQSUM_W - 1);
        end else if (ctl.div_step) begin
            r_quo_a <= {r_quo_a[SQSUM_W-2:0], w_ge_a};
            r_rem_a <= w_ge_a ? w_da[CNT_W-1:0] : w_ta[CNT_W-1:0];
            r_quo_b <= {r_quo_b[SQSUM_W-2:0], w_ge_b};
            r_rem_b <= w_ge_b ? w_db[CNT_W-1:0] : w_tb[CNT_W-1:0];
            r_step  <= (r_step == '0) ? STEP_W'(ROOT_W - 1) : r_step - 1'b1;
        end else if (ctl.sqrt_step) begin
            r_quo_b <= r_quo_b << 2;
            r_srem  <= w_ge_s ? w_sdiff[ROOT_W-1:0] : w_cur[ROOT_W-1:0];
            r_root  <= {r_root[ROOT_W-2:0], w_ge_s};
            r_step  <= r_step - 1'b1;
        end
    end

    // Result fields; the mean is the quotient magnitude with the sum's sign.
    assign w_qa               = r_quo_a[SAMPLE_BITS-1:0];
    assign w_res.mean_value   = r_neg ? -w_qa : w_qa;
    assign w_res.rms_value    = r_root;
    assign w_res.minimum      = r_min;
    assign w_res.maximum      = r_max;
    assign w_res.peak_to_peak = r_max - r_min;
    assign w_res.sample_count = r_cnt;
    assign w_res.overflow     = r_ovf;

    // Result register; it frees as the receiver takes the transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
        if (ctl.out_load) begin
            r_out <= w_res;
        end
    end

    assign empty       = !r_out_valid;
    assign o_stat_item = r_out;

    a_load_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load |-> !i_q_status.empty)
        else $error("window taken from an empty queue");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |=> (r_out_valid && r_state == BK_IDLE))
        else $error("result register not loaded after hold");

    a_sqrt_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SQRT) |-> (r_step < STEP_W'(ROOT_W)))
        else $error("square root step count out of range");

endmodule

>>> rtl/signal_window_statistics_unit.sv
`timescale 1ns / 1ps
// Top level of the window statistics unit: front end, window queue and back end.
//
// Usage: samples enter through a queue-style port (push / full). A transaction
// with last set closes the window. Results leave through a queue-style port
// (empty / pop): while empty is low the oldest result is on o_stat_item, and
// pop takes it.
// Throughput: one sample per cycle while full is low. Each closed window
// occupies the serial divider and square root unit for one load, 43 division
// steps, 16 square root steps and one hold. Up to two closed windows wait in
// the queue, so full rises only when closed windows keep arriving faster
// than the back end finishes them, or when results are not popped. Empty
// goes low once a window has passed the queue, both serial units and the hold.
// While a result waits unpopped, the back end holds its next result and the
// front end keeps accumulating until a closing sample finds the queue full.
// Reset (synchronous, active low) clears the window totals, empties the queue
// and the result register; samples are accepted as soon as reset is released.
module signal_window_statistics_unit
    import swsu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         push,
    output logic         full,
    input  t_sample_item i_sample_item,
    output logic         empty,
    input  logic         pop,
    output t_stat_item   o_stat_item
);

    t_q_status   q_status;
    logic        rec_push;
    logic        rec_pop;
    t_window_rec rec_in;
    t_window_rec rec_out;

    // Sample intake and running totals.
    swsu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_sample_item (i_sample_item),
        .i_q_status    (q_status),
        .o_rec_push    (rec_push),
        .o_rec         (rec_in)
    );

    // Closed windows waiting for the arithmetic.
    swsu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (rec_push),
        .i_rec    (rec_in),
        .i_pop    (rec_pop),
        .o_rec    (rec_out),
        .o_status (q_status)
    );

    // Division, square root and result register.
    swsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_rec       (rec_out),
        .o_q_pop     (rec_pop),
        .empty       (empty),
        .pop         (pop),
        .o_stat_item (o_stat_item)
    );

endmodule
